### sv/wrh_pkg.sv
// shared constants, types and tap table for the windowed rate history block
package wrh_pkg;

   // history geometry
   localparam int DEPTH      = 128;
   localparam int PTR_BITS   = $clog2(DEPTH);
   localparam int COUNT_BITS = 64;
   localparam int ROW_BITS   = 2 * COUNT_BITS;
   localparam int RATE_BITS  = 64;

   // newest entry and the three lags behind it
   localparam int NEWEST_IDX = DEPTH - 2;
   localparam int LAG_SHORT  = 6;
   localparam int LAG_MID    = 6 * 5;
   localparam int LAG_LONG   = 6 * 15;

   // rounded rates reduce to small divisors:
   //   short: round(100 d / 60)  = floor((5 d + 1) / 3)
   //   mid:   round(100 d / 300) = floor((d + 1) / 3)
   //   long:  round(100 d / 900) = floor((d + 4) / 9)
   localparam int SHORT_DIVISOR = 3;
   localparam int MID_DIVISOR   = 3;
   localparam int LONG_DIVISOR  = 9;
   localparam int SHORT_OFFSET  = 1;
   localparam int MID_OFFSET    = 1;
   localparam int LONG_OFFSET   = 4;

   // reciprocal divider lanes: dividend and reciprocal split into three chunks,
   // one chunk product accumulated per cycle
   localparam int QUOT_BITS     = 72;
   localparam int CHUNKS        = 3;
   localparam int X_CHUNK_BITS  = QUOT_BITS / CHUNKS;
   localparam int RECIP_BITS    = 75;
   localparam int M_CHUNK_BITS  = RECIP_BITS / CHUNKS;
   localparam int PP_BITS       = X_CHUNK_BITS + M_CHUNK_BITS;
   localparam int PROD_BITS     = QUOT_BITS + RECIP_BITS;
   localparam int RECIP_SHIFT   = QUOT_BITS + 4;
   localparam int DIV_STEPS     = CHUNKS * CHUNKS;
   localparam int STEP_CNT_BITS = $clog2(DIV_STEPS);

   // scaled reciprocals ceil(2^76 / d); exact quotients for any 72-bit dividend
   localparam logic [RECIP_SHIFT-1:0] SCALE_MAX = '1;
   localparam logic [RECIP_BITS-1:0]  SHORT_RECIP =
      RECIP_BITS'(SCALE_MAX / RECIP_SHIFT'(SHORT_DIVISOR) + RECIP_SHIFT'(1));
   localparam logic [RECIP_BITS-1:0]  MID_RECIP =
      RECIP_BITS'(SCALE_MAX / RECIP_SHIFT'(MID_DIVISOR) + RECIP_SHIFT'(1));
   localparam logic [RECIP_BITS-1:0]  LONG_RECIP =
      RECIP_BITS'(SCALE_MAX / RECIP_SHIFT'(LONG_DIVISOR) + RECIP_SHIFT'(1));

   // item command codes
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   // ring select codes
   localparam logic RING_TRX   = 1'b0;
   localparam logic RING_QUERY = 1'b1;

   // history taps read by a query
   typedef enum logic [1:0] {
      TAP_NOW,
      TAP_SHORT,
      TAP_MID,
      TAP_LONG
   } tap_sel_type;

   localparam int TAP_COUNT = 4;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_WAIT,
      ST_DIFF,
      ST_LOAD,
      ST_DIV,
      ST_DONE
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic        sample_we;
      logic        query_load;
      logic        rd_en;
      tap_sel_type rd_tap;
      logic        diff_en;
      logic        div_load;
      logic        div_step;
   } dp_cmd_type;

   // history index of each tap, counted from the oldest entry
   function automatic logic [PTR_BITS-1:0] tap_index(input tap_sel_type tap);
      logic [PTR_BITS-1:0] idx;
      case (tap)
         TAP_NOW:   idx = PTR_BITS'(NEWEST_IDX);
         TAP_SHORT: idx = PTR_BITS'(NEWEST_IDX - LAG_SHORT);
         TAP_MID:   idx = PTR_BITS'(NEWEST_IDX - LAG_MID);
         TAP_LONG:  idx = PTR_BITS'(NEWEST_IDX - LAG_LONG);
         default:   idx = PTR_BITS'(NEWEST_IDX);
      endcase
      return idx;
   endfunction

endpackage

### sv/wrh_cdiv.sv
// divider lane for a small constant divisor, multiplying by its scaled reciprocal
module wrh_cdiv (
   input  logic                           clock,
   input  logic                           load,
   input  logic                           step,
   input  logic [wrh_pkg::QUOT_BITS-1:0]  dividend,
   input  logic [wrh_pkg::RECIP_BITS-1:0] recip,
   output logic [wrh_pkg::QUOT_BITS-1:0]  quotient
);
   import wrh_pkg::*;

   logic [QUOT_BITS-1:0]    num_ff;
   logic [PROD_BITS-1:0]    acc_ff;
   logic [PROD_BITS-1:0]    acc_in;
   logic [1:0]              xi_ff;
   logic [1:0]              xi_in;
   logic [1:0]              mj_ff;
   logic [1:0]              mj_in;
   logic [X_CHUNK_BITS-1:0] x_part;
   logic [M_CHUNK_BITS-1:0] m_part;
   logic [7:0]              x_shift;
   logic [7:0]              m_shift;
   logic [PP_BITS-1:0]      pp;
   logic [PROD_BITS-1:0]    pp_wide;

   // one chunk product, shifted to its weight and accumulated
   always_comb begin
      case (xi_ff)
         2'd0: begin
            x_part  = num_ff[X_CHUNK_BITS-1:0];
            x_shift = 8'd0;
         end
         2'd1: begin
            x_part  = num_ff[2*X_CHUNK_BITS-1:X_CHUNK_BITS];
            x_shift = 8'(X_CHUNK_BITS);
         end
         default: begin
            x_part  = num_ff[3*X_CHUNK_BITS-1:2*X_CHUNK_BITS];
            x_shift = 8'(2 * X_CHUNK_BITS);
         end
      endcase
      case (mj_ff)
         2'd0: begin
            m_part  = recip[M_CHUNK_BITS-1:0];
            m_shift = 8'd0;
         end
         2'd1: begin
            m_part  = recip[2*M_CHUNK_BITS-1:M_CHUNK_BITS];
            m_shift = 8'(M_CHUNK_BITS);
         end
         default: begin
            m_part  = recip[3*M_CHUNK_BITS-1:2*M_CHUNK_BITS];
            m_shift = 8'(2 * M_CHUNK_BITS);
         end
      endcase
      pp      = PP_BITS'(x_part) * PP_BITS'(m_part);
      pp_wide = PROD_BITS'(pp) << (x_shift + m_shift);
      acc_in  = acc_ff + pp_wide;
      // reciprocal chunk runs fastest, dividend chunk advances on its wrap
      if (mj_ff == 2'(CHUNKS - 1)) begin
         mj_in = '0;
         xi_in = xi_ff + 2'd1;
      end else begin
         mj_in = mj_ff + 2'd1;
         xi_in = xi_ff;
      end
   end

   // lane registers
   always_ff @(posedge clock) begin
      if (load) begin
         num_ff <= dividend;
         acc_ff <= '0;
         xi_ff  <= '0;
         mj_ff  <= '0;
      end else if (step) begin
         acc_ff <= acc_in;
         xi_ff  <= xi_in;
         mj_ff  <= mj_in;
      end
   end

   assign quotient = QUOT_BITS'(acc_ff[PROD_BITS-1:RECIP_SHIFT]);

endmodule

### sv/wrh_ctrl.sv
// controller state machine sequencing samples and rate queries
module wrh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_cmd,
   output logic                busy,
   output logic                rsp_strobe,
   output wrh_pkg::dp_cmd_type dp_cmd
);
   import wrh_pkg::*;

   state_type                state_ff;
   state_type                state_in;
   logic [1:0]               tap_cnt_ff;
   logic [1:0]               tap_cnt_in;
   logic [STEP_CNT_BITS-1:0] step_cnt_ff;
   logic [STEP_CNT_BITS-1:0] step_cnt_in;

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         tap_cnt_ff  <= '0;
         step_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         tap_cnt_ff  <= tap_cnt_in;
         step_cnt_ff <= step_cnt_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in    = state_ff;
      tap_cnt_in  = tap_cnt_ff;
      step_cnt_in = step_cnt_ff;
      dp_cmd      = '0;
      dp_cmd.rd_tap = tap_sel_type'(tap_cnt_ff);
      busy        = 1'b1;
      rsp_strobe  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (req_cmd == CMD_QUERY) begin
                  dp_cmd.query_load = 1'b1;
                  tap_cnt_in        = '0;
                  state_in          = ST_READ;
               end else begin
                  dp_cmd.sample_we = 1'b1;
               end
            end
         end
         ST_READ: begin
            dp_cmd.rd_en = 1'b1;
            tap_cnt_in   = tap_cnt_ff + 2'd1;
            if (tap_cnt_ff == 2'(TAP_COUNT - 1)) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            dp_cmd.diff_en = 1'b1;
            state_in       = ST_LOAD;
         end
         ST_LOAD: begin
            dp_cmd.div_load = 1'b1;
            step_cnt_in     = '0;
            state_in        = ST_DIV;
         end
         ST_DIV: begin
            dp_cmd.div_step = 1'b1;
            step_cnt_in     = step_cnt_ff + STEP_CNT_BITS'(1);
            if (step_cnt_ff == STEP_CNT_BITS'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_strobe = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### sv/wrh_datapath.sv
// history rings, pointers, tap capture and rate arithmetic
module wrh_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  wrh_pkg::dp_cmd_type            dp_cmd,
   input  logic [wrh_pkg::COUNT_BITS-1:0] req_query_total,
   input  logic [wrh_pkg::COUNT_BITS-1:0] req_trx_total,
   input  logic                           req_ring_select,
   output logic [wrh_pkg::RATE_BITS-1:0]  rsp_rate_short,
   output logic [wrh_pkg::RATE_BITS-1:0]  rsp_rate_mid,
   output logic [wrh_pkg::RATE_BITS-1:0]  rsp_rate_long
);
   import wrh_pkg::*;

   // both rings share one row: query count high, transaction count low
   logic [ROW_BITS-1:0]   hist_mem [DEPTH];
   logic [DEPTH-1:0]      valid_ff;
   logic [PTR_BITS-1:0]   write_ptr_ff;
   logic [PTR_BITS-1:0]   write_ptr_in;
   logic [PTR_BITS-1:0]   oldest_ptr_ff;
   logic [PTR_BITS-1:0]   oldest_ptr_in;
   logic [PTR_BITS-1:0]   fill;
   logic [PTR_BITS-1:0]   rd_idx;
   logic [PTR_BITS-1:0]   rd_addr;
   logic                  ring_sel_ff;
   logic [ROW_BITS-1:0]   rd_row_ff;
   logic                  rd_live_ff;
   logic                  rd_live_in;
   logic                  rd_pend_ff;
   tap_sel_type           rd_tap_ff;
   logic [COUNT_BITS-1:0] rd_entry;
   logic [COUNT_BITS-1:0] entry_ff [TAP_COUNT];
   logic [COUNT_BITS-1:0] diff_short_ff;
   logic [COUNT_BITS-1:0] diff_mid_ff;
   logic [COUNT_BITS-1:0] diff_long_ff;
   logic [QUOT_BITS-1:0]  num_short;
   logic [QUOT_BITS-1:0]  num_mid;
   logic [QUOT_BITS-1:0]  num_long;
   logic [QUOT_BITS-1:0]  quot_short;
   logic [QUOT_BITS-1:0]  quot_mid;
   logic [QUOT_BITS-1:0]  quot_long;

   // pointer arithmetic and read address
   always_comb begin
      fill          = write_ptr_ff - oldest_ptr_ff;
      oldest_ptr_in = oldest_ptr_ff;
      write_ptr_in  = write_ptr_ff;
      if (dp_cmd.sample_we) begin
         if (fill == PTR_BITS'(DEPTH - 1)) begin
            oldest_ptr_in = oldest_ptr_ff + PTR_BITS'(1);
         end
         write_ptr_in = write_ptr_ff + PTR_BITS'(1);
      end
      rd_idx     = tap_index(dp_cmd.rd_tap);
      rd_addr    = oldest_ptr_ff + rd_idx;
      rd_live_in = valid_ff[rd_addr] && (rd_idx < fill);
   end

   // control registers: pointers, valid bits, read tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         write_ptr_ff  <= PTR_BITS'(NEWEST_IDX);
         oldest_ptr_ff <= '0;
         valid_ff      <= '0;
         rd_pend_ff    <= 1'b0;
      end else begin
         write_ptr_ff  <= write_ptr_in;
         oldest_ptr_ff <= oldest_ptr_in;
         rd_pend_ff    <= dp_cmd.rd_en;
         if (dp_cmd.sample_we) begin
            valid_ff[write_ptr_ff] <= 1'b1;
         end
      end
   end

   // history memory, one write or one registered read a cycle
   always_ff @(posedge clock) begin
      if (dp_cmd.sample_we) begin
         hist_mem[write_ptr_ff] <= {req_query_total, req_trx_total};
      end
      if (dp_cmd.rd_en) begin
         rd_row_ff  <= hist_mem[rd_addr];
         rd_live_ff <= rd_live_in;
         rd_tap_ff  <= dp_cmd.rd_tap;
      end
   end

   // pick the selected ring; unwritten or past-fill entries read zero
   always_comb begin
      rd_entry = '0;
      if (rd_live_ff) begin
         if (ring_sel_ff == RING_QUERY) begin
            rd_entry = rd_row_ff[ROW_BITS-1:COUNT_BITS];
         end else begin
            rd_entry = rd_row_ff[COUNT_BITS-1:0];
         end
      end
   end

   // ring select, tap capture and differences
   always_ff @(posedge clock) begin
      if (dp_cmd.query_load) begin
         ring_sel_ff <= req_ring_select;
      end
      if (rd_pend_ff) begin
         entry_ff[rd_tap_ff] <= rd_entry;
      end
      if (dp_cmd.diff_en) begin
         diff_short_ff <= entry_ff[TAP_NOW] - entry_ff[TAP_SHORT];
         diff_mid_ff   <= entry_ff[TAP_NOW] - entry_ff[TAP_MID];
         diff_long_ff  <= entry_ff[TAP_NOW] - entry_ff[TAP_LONG];
      end
   end

   // rounding offsets folded into the dividends
   always_comb begin
      num_short = QUOT_BITS'({diff_short_ff, 2'b00}) + QUOT_BITS'(diff_short_ff)
                  + QUOT_BITS'(SHORT_OFFSET);
      num_mid   = QUOT_BITS'(diff_mid_ff) + QUOT_BITS'(MID_OFFSET);
      num_long  = QUOT_BITS'(diff_long_ff) + QUOT_BITS'(LONG_OFFSET);
   end

   // three divider lanes working side by side
   wrh_cdiv u_div_short (
      .clock    (clock),
      .load     (dp_cmd.div_load),
      .step     (dp_cmd.div_step),
      .dividend (num_short),
      .recip    (SHORT_RECIP),
      .quotient (quot_short)
   );

   wrh_cdiv u_div_mid (
      .clock    (clock),
      .load     (dp_cmd.div_load),
      .step     (dp_cmd.div_step),
      .dividend (num_mid),
      .recip    (MID_RECIP),
      .quotient (quot_mid)
   );

   wrh_cdiv u_div_long (
      .clock    (clock),
      .load     (dp_cmd.div_load),
      .step     (dp_cmd.div_step),
      .dividend (num_long),
      .recip    (LONG_RECIP),
      .quotient (quot_long)
   );

   // saturate to the rate width
   always_comb begin
      rsp_rate_short = (|quot_short[QUOT_BITS-1:RATE_BITS]) ? '1 : quot_short[RATE_BITS-1:0];
      rsp_rate_mid   = (|quot_mid[QUOT_BITS-1:RATE_BITS])   ? '1 : quot_mid[RATE_BITS-1:0];
      rsp_rate_long  = (|quot_long[QUOT_BITS-1:RATE_BITS])  ? '1 : quot_long[RATE_BITS-1:0];
   end

endmodule

### sv/windowed_rate_history.sv
// top level of the windowed rate history meter
//
// channel   direction  handshake                     payload
// req_      in         start high while busy low     cmd, query_total, trx_total, ring_select
// rsp_      out        rsp_strobe for one cycle      rate_short, rate_mid, rate_long
//
// a sample item leaves busy low, so the next item may follow at once
// a query item keeps busy high through four reads from the one history port, a wait
// for the registered read, the differences, the divider load, nine
// reciprocal multiply-accumulate steps, then rsp_strobe with the rates
// reset is synchronous; valid bits make the whole history read as zero straight after
// results cannot be held off: the receiver takes each one in the strobe cycle
module windowed_rate_history (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_cmd,
   input  logic [wrh_pkg::COUNT_BITS-1:0] req_query_total,
   input  logic [wrh_pkg::COUNT_BITS-1:0] req_trx_total,
   input  logic                           req_ring_select,
   output logic                           rsp_strobe,
   output logic [wrh_pkg::RATE_BITS-1:0]  rsp_rate_short,
   output logic [wrh_pkg::RATE_BITS-1:0]  rsp_rate_mid,
   output logic [wrh_pkg::RATE_BITS-1:0]  rsp_rate_long
);
   import wrh_pkg::*;

   dp_cmd_type dp_cmd;

   // sequencing
   wrh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_cmd    (req_cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .dp_cmd     (dp_cmd)
   );

   // storage and arithmetic
   wrh_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .dp_cmd          (dp_cmd),
      .req_query_total (req_query_total),
      .req_trx_total   (req_trx_total),
      .req_ring_select (req_ring_select),
      .rsp_rate_short  (rsp_rate_short),
      .rsp_rate_mid    (rsp_rate_mid),
      .rsp_rate_long   (rsp_rate_long)
   );

endmodule
